FILE: rtl/bcal_pkg.sv
// Shared types and constants of the baseline offset calibrator.
package bcal_pkg;

    localparam int CH_W     = 3;
    localparam int NREG     = 8;
    localparam int TGT_W    = 16;
    localparam int WORD_W   = 32;
    localparam int SIZE_W   = 28;
    localparam int SUM_W    = 48;
    localparam int N_W      = SIZE_W + 1;
    localparam int PROD_W   = TGT_W + N_W;
    localparam int MAX_F    = 8;
    localparam int DIV_DW   = SUM_W + MAX_F;
    localparam int DIV_VW   = N_W;
    localparam int Q_W      = DIV_DW + 1;
    localparam int LVL_W    = 16;
    localparam int Q4_W     = 21;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;
    localparam int NCH_DEF  = 8;
    localparam int ADC_DEF  = 14;
    localparam int DAC_DEF  = 16;

    localparam logic [11:0]       HDR_MARK = 12'hA00;
    localparam logic [WORD_W-1:0] FILLER   = 32'hFFFF_FFFF;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    typedef enum logic [1:0] {
        OP_EVENT  = 2'd0,
        OP_PRESET = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FILLED, PH_MASK, PH_SKIP1, PH_SKIP2, PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        C_IDLE, C_WPC, C_MUL, C_SUB, C_CONV, C_DIV, C_FIN
    } t_cst;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              rem_nz;
        logic [DIV_DW-1:0] quo;
    } t_div_rsp;

endpackage

FILE: rtl/bcal_div.sv
// Restoring divider, one quotient bit per cycle.
module bcal_div import bcal_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_VW-1:0] r_rem, r_div;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW:0]   trial, n_rem;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_quo[DIV_DW-1]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? trial - {1'b0, r_div} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem[DIV_VW-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], ge};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.rem_nz = |r_rem;
    assign o_rsp.quo    = r_quo;

endmodule

FILE: rtl/baseline_offset_calibrator.sv
// Baseline offset calibrator: event parser, update sequencer and channel stores.
//
// Input stream (i_s_*): one transaction per event word or control op. Event
// words are taken one per cycle. The mask word starts a split of the payload
// over the masked channels, and the last word of an active channel starts the
// offset update; both run on one shared bit-serial divider, so the block
// drops o_s_tready while the split (mask word) or the update (channel end)
// runs, before taking the next word.
// Output stream (o_m_*): at most one result per input transaction, either a
// channel update (tuser 0) or a header error (tuser 1, tdata zero). A header
// error appears in the cycle after its word. The result sits in an output
// register; while it waits and the receiver stalls, o_s_tready stays low and
// no transaction is taken, so a waiting result is never overwritten.
// Config port: i_cfg_we writes target i_cfg_addr; write only while idle.
// Reset (synchronous, active low) clears the parser, all converged flags,
// the DAC levels and targets, and empties the output register.
module baseline_offset_calibrator import bcal_pkg::*; #(
    parameter int NUM_CHANNELS = NCH_DEF,
    parameter int ADC_BITS     = ADC_DEF,
    parameter int DAC_BITS     = DAC_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // op[1:0], word[33:2], channel[36:34]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // channel_res[2:0], dac_level[18:3],
                                          // mean_diff_q4[39:19], converged[40],
                                          // all_converged[41]
    output logic             o_m_tuser,   // kind
    input  logic             i_cfg_we,
    input  logic [CH_W-1:0]  i_cfg_addr,
    input  logic [TGT_W-1:0] i_cfg_data
);
    // scale shifts: Q = floor(num * 2^F / n), corr and q4 taken from Q by floors
    localparam int SHIFT   = DAC_BITS - ADC_BITS;
    localparam int F       = (SHIFT > 4) ? SHIFT : 4;
    localparam int SH_CORR = F - SHIFT;
    localparam int SH_Q4   = F - 4;
    localparam logic [7:0] CH_MASK = 8'((1 << NUM_CHANNELS) - 1);

    // stores
    logic [TGT_W-1:0] r_target [NREG];
    logic [LVL_W-1:0] r_dac [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_done;

    // parser state
    t_phase           r_phase;
    logic [7:0]       r_event_mask, r_pending;
    logic [SIZE_W-1:0] r_payload, r_words_left, r_wpc, r_wc;
    logic [CH_W-1:0]  r_cur;
    logic             r_open, r_active;
    logic [SUM_W-1:0] r_sum;

    // update sequencer
    t_cst             r_cst, n_cst;
    logic [CH_W-1:0]  r_calc_ch;
    logic [SUM_W-1:0] r_calc_sum;
    logic [N_W-1:0]   r_n;
    logic [PROD_W-1:0] r_prod;
    logic             r_neg, r_conv;
    logic [SUM_W-1:0] r_mag;
    logic signed [Q_W-1:0] r_q;

    // output register
    logic             r_out_valid, r_out_kind;
    logic [OUT_W-1:0] r_out_data;

    t_div_req div_req;
    t_div_rsp div_rsp;

    bcal_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // input fields
    logic [1:0]        in_op;
    logic [WORD_W-1:0] in_word;
    logic [CH_W-1:0]   in_ch;
    logic              accept, out_free;

    assign in_op   = i_s_tdata[1:0];
    assign in_word = i_s_tdata[33:2];
    assign in_ch   = i_s_tdata[36:34];
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_cst == C_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // header / mask decode
    logic [7:0]        m_bits;
    logic [3:0]        m_cnt;
    logic              mask_bad;
    logic [SIZE_W-1:0] hdr_size;

    always_comb begin
        m_bits = in_word[7:0] & CH_MASK;
        m_cnt  = '0;
        for (int c = 0; c < 8; c++) begin
            m_cnt = m_cnt + 4'(m_bits[c]);
        end
        mask_bad = (in_word[31:28] != 4'd0) || (m_cnt == 4'd0) ||
                   (r_payload < SIZE_W'(m_cnt));
        hdr_size = in_word[SIZE_W-1:0];
    end

    // lowest pending channel
    function automatic logic [3:0] first_set(input logic [7:0] m);
        logic [3:0] r;
        r = 4'b0000;
        for (int c = 7; c >= 0; c--) begin
            if (m[c]) begin
                r = {1'b1, 3'(c)};
            end
        end
        return r;
    endfunction

    // data word arithmetic
    logic [SUM_W-1:0]  sum_add;
    logic [SIZE_W-1:0] wc_next, wl_next;
    logic [7:0]        open_src;
    logic [3:0]        pick;
    logic              chan_end, start_upd, is_data, is_skip2, is_mask_ok;

    always_comb begin
        sum_add  = r_sum + SUM_W'(in_word[15:0]) + SUM_W'(in_word[31:16]);
        wc_next  = r_wc + 1'b1;
        wl_next  = (r_words_left != '0) ? r_words_left - 1'b1 : r_words_left;
        is_data  = accept && (in_op == OP_EVENT) && (r_phase == PH_DATA);
        is_skip2 = accept && (in_op == OP_EVENT) && (r_phase == PH_SKIP2);
        is_mask_ok = accept && (in_op == OP_EVENT) && (r_phase == PH_MASK) &&
                     !mask_bad;
        chan_end  = is_data && r_open && (wc_next >= r_wpc);
        start_upd = chan_end && r_active;
        open_src  = is_skip2 ? r_event_mask : r_pending;
        pick      = first_set(open_src);
    end

    // update arithmetic
    logic [SUM_W:0]        diff;
    logic [N_W+1:0]        n3;
    logic signed [Q_W-1:0] q_corr, q_q4;
    logic signed [Q_W:0]   lvl_full;
    logic [LVL_W-1:0]      lvl_sat;
    logic [Q4_W-1:0]       q4_sat;
    logic [NUM_CHANNELS-1:0] done_new;
    logic                  all_conv;

    always_comb begin
        diff     = {1'b0, r_calc_sum} - (SUM_W+1)'(r_prod);
        n3       = {1'b0, r_n, 1'b0} + (N_W+2)'(r_n);
        q_corr   = r_q >>> SH_CORR;
        q_q4     = r_q >>> SH_Q4;
        lvl_full = (Q_W+1)'(signed'({1'b0, r_dac[r_calc_ch]})) + (Q_W+1)'(q_corr);
        if (lvl_full < 0) begin
            lvl_sat = '0;
        end else if (lvl_full > (Q_W+1)'(65535)) begin
            lvl_sat = '1;
        end else begin
            lvl_sat = lvl_full[LVL_W-1:0];
        end
        if (q_q4 > Q_W'(1048575)) begin
            q4_sat = {1'b0, {(Q4_W-1){1'b1}}};
        end else if (q_q4 < -Q_W'(1048576)) begin
            q4_sat = {1'b1, {(Q4_W-1){1'b0}}};
        end else begin
            q4_sat = q_q4[Q4_W-1:0];
        end
        done_new = r_done;
        if (r_conv) begin
            done_new[r_calc_ch] = 1'b1;
        end
        all_conv = &(~r_event_mask[NUM_CHANNELS-1:0] | done_new);
    end

    // divider request
    always_comb begin
        div_req = '0;
        if (is_mask_ok) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DW'(r_payload);
            div_req.divisor  = DIV_VW'(m_cnt);
        end else if (r_cst == C_CONV) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DW'(r_mag) << F;
            div_req.divisor  = r_n;
        end
    end

    // sequencer next state
    always_comb begin
        n_cst = r_cst;
        case (r_cst)
            C_IDLE: begin
                if (is_mask_ok) begin
                    n_cst = C_WPC;
                end else if (start_upd) begin
                    n_cst = C_MUL;
                end
            end
            C_WPC:  if (div_rsp.done) n_cst = C_IDLE;
            C_MUL:  n_cst = C_SUB;
            C_SUB:  n_cst = C_CONV;
            C_CONV: n_cst = C_DIV;
            C_DIV:  if (div_rsp.done) n_cst = C_FIN;
            C_FIN:  if (out_free) n_cst = C_IDLE;
            default: n_cst = C_IDLE;
        endcase
    end

    // output register loads
    logic             out_load, out_err;
    always_comb begin
        out_err  = 1'b0;
        out_load = 1'b0;
        if (accept && (in_op == OP_EVENT)) begin
            case (r_phase)
                PH_IDLE, PH_FILLED:
                    out_err = (in_word[31:20] != HDR_MARK) &&
                              !((in_word == FILLER) && (r_phase == PH_IDLE));
                PH_MASK: out_err = mask_bad;
                default: out_err = 1'b0;
            endcase
        end
        out_load = out_err || ((r_cst == C_FIN) && out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst       <= C_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_cst <= n_cst;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_err) begin
            r_out_kind <= KIND_ERROR;
            r_out_data <= '0;
        end else if (out_load) begin
            r_out_kind <= KIND_UPDATE;
            r_out_data <= {6'd0, all_conv, r_conv, q4_sat, lvl_sat, r_calc_ch};
        end
    end

    // update datapath
    always_ff @(posedge i_clk) begin
        case (r_cst)
            C_MUL: begin
                r_prod <= PROD_W'(r_target[r_calc_ch] * r_n);
            end
            C_SUB: begin
                r_neg <= diff[SUM_W];
                r_mag <= diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
            end
            C_CONV: begin
                r_conv <= (SUM_W+1)'(r_mag) < (SUM_W+1)'(n3);
            end
            C_DIV: begin
                if (div_rsp.done) begin
                    if (!r_neg) begin
                        r_q <= signed'({1'b0, div_rsp.quo});
                    end else if (div_rsp.rem_nz) begin
                        r_q <= signed'(~{1'b0, div_rsp.quo});
                    end else begin
                        r_q <= signed'(-{1'b0, div_rsp.quo});
                    end
                end
            end
            default: begin
            end
        endcase
        if (start_upd) begin
            r_calc_ch  <= r_cur;
            r_calc_sum <= sum_add;
            r_n        <= {r_wpc, 1'b0};
        end
    end

    // parser, stores and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_event_mask <= '0;
            r_pending    <= '0;
            r_payload    <= '0;
            r_words_left <= '0;
            r_wpc        <= '0;
            r_wc         <= '0;
            r_cur        <= '0;
            r_open       <= 1'b0;
            r_active     <= 1'b0;
            r_sum        <= '0;
            r_done       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) r_dac[i] <= '0;
            for (int i = 0; i < NREG; i++) r_target[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_target[i_cfg_addr] <= i_cfg_data;
            end
            if ((r_cst == C_WPC) && div_rsp.done) begin
                r_wpc <= div_rsp.quo[SIZE_W-1:0];
            end
            if ((r_cst == C_FIN) && out_free) begin
                r_dac[r_calc_ch] <= lvl_sat;
                r_done           <= done_new;
            end
            if (accept) begin
                case (in_op)
                    OP_PRESET: begin
                        if (32'(in_ch) < NUM_CHANNELS) begin
                            r_dac[in_ch] <= in_word[LVL_W-1:0];
                        end
                    end
                    OP_CLEAR: r_done <= '0;
                    OP_EVENT: begin
                        case (r_phase)
                            PH_IDLE, PH_FILLED: begin
                                if (in_word[31:20] == HDR_MARK) begin
                                    r_payload <= (hdr_size >= SIZE_W'(4)) ?
                                                 hdr_size - SIZE_W'(4) : '0;
                                    r_phase   <= PH_MASK;
                                end else if ((in_word == FILLER) &&
                                             (r_phase == PH_IDLE)) begin
                                    r_phase <= PH_FILLED;
                                end else begin
                                    r_phase <= PH_IDLE;
                                end
                            end
                            PH_MASK: begin
                                if (mask_bad) begin
                                    r_phase <= PH_IDLE;
                                end else begin
                                    r_event_mask <= m_bits;
                                    r_words_left <= r_payload;
                                    r_phase      <= PH_SKIP1;
                                end
                            end
                            PH_SKIP1: r_phase <= PH_SKIP2;
                            PH_SKIP2: begin
                                r_phase   <= PH_DATA;
                                r_pending <= open_src & ~(8'd1 << pick[2:0]);
                                r_open    <= pick[3];
                                r_active  <= pick[3] && !r_done[pick[2:0]];
                                r_cur     <= pick[2:0];
                                r_sum     <= '0;
                                r_wc      <= '0;
                            end
                            PH_DATA: begin
                                if (chan_end) begin
                                    r_pending <= open_src & ~(8'd1 << pick[2:0]);
                                    r_cur     <= pick[2:0];
                                    r_sum     <= '0;
                                    r_wc      <= '0;
                                end else if (r_open) begin
                                    if (r_active) r_sum <= sum_add;
                                    r_wc <= wc_next;
                                end
                                r_words_left <= wl_next;
                                // payload exhausted: close the event
                                if (wl_next == '0) begin
                                    r_phase  <= PH_IDLE;
                                    r_open   <= 1'b0;
                                    r_active <= 1'b0;
                                end else if (chan_end) begin
                                    r_open   <= pick[3];
                                    r_active <= pick[3] && !r_done[pick[2:0]];
                                end
                            end
                            default: r_phase <= PH_IDLE;
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

    // no input taken while the sequencer is busy
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cst != C_IDLE) |-> !o_s_tready)
        else $error("input taken during update");

    // an error result carries an all-zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_ERROR)) |-> (r_out_data == '0))
        else $error("error result with payload");

    // finishing an update always presents an update result
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cst == C_FIN) && out_free) |=> (r_out_valid && (r_out_kind == KIND_UPDATE)))
        else $error("update result lost");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the baseline offset calibrator: event stimulus, predictor, checks.
module testbench;
    import bcal_pkg::*;

    localparam int LIMIT      = 1_000_000;
    localparam int ITEMS      = 1550;
    localparam int SETTLE     = 100;   // longer than one divider pass
    localparam int N_CH       = NCH_DEF;
    localparam int GAIN_SHIFT = DAC_DEF - ADC_DEF;

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] data;
    } t_res;

    // Predictor of the calibrator plus the queue of results it still expects.
    class offset_scoreboard;
        logic [15:0] target [N_CH];
        logic [15:0] dac [N_CH];
        bit          done [N_CH];
        t_phase      phase;
        logic [7:0]  ev_mask, pend;
        int unsigned psize, left, wpc, wcnt, cur;
        bit          ch_open, ch_active;
        longint      sum;
        t_res        pending_results [$];
        int          mismatches, n_updates, n_errors;

        function new();
            for (int i = 0; i < N_CH; i++) begin
                target[i] = '0;
                dac[i] = '0;
                done[i] = 0;
            end
            phase = PH_IDLE;
            ev_mask = '0;
            pend = '0;
            psize = 0;
            left = 0;
            wpc = 0;
            wcnt = 0;
            cur = 0;
            ch_open = 0;
            ch_active = 0;
            sum = 0;
            mismatches = 0;
            n_updates = 0;
            n_errors = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function void open_next();
            bit found;
            found = 0;
            for (int c = 0; c < N_CH; c++) begin
                if (!found && pend[c]) begin
                    found = 1;
                    pend[c] = 1'b0;
                    cur = c;
                    ch_open = 1;
                    ch_active = !done[c];
                    sum = 0;
                    wcnt = 0;
                end
            end
            if (!found) begin
                ch_open = 0;
                ch_active = 0;
            end
        endfunction

        function void push_error();
            t_res r;
            r.kind = KIND_ERROR;
            r.data = '0;
            pending_results = {pending_results, r};
        endfunction

        function void push_update();
            longint n, num, corr, lvl, q4;
            bit conv, all;
            t_res r;
            n = longint'(wpc) * 2;
            num = sum - longint'(target[cur]) * n;
            corr = fdiv(num * (longint'(1) << GAIN_SHIFT), n);
            lvl = longint'(dac[cur]) + corr;
            if (lvl < 0) lvl = 0;
            if (lvl > 65535) lvl = 65535;
            dac[cur] = lvl[15:0];
            q4 = fdiv(num * 16, n);
            if (q4 > 1048575) q4 = 1048575;
            if (q4 < -1048576) q4 = -1048576;
            conv = (num < 3 * n) && (num > -3 * n);
            if (conv) done[cur] = 1;
            all = 1;
            for (int c = 0; c < N_CH; c++)
                if (ev_mask[c] && !done[c]) all = 0;
            r.kind = KIND_UPDATE;
            r.data = '0;
            r.data[2:0] = cur[2:0];
            r.data[18:3] = lvl[15:0];
            r.data[39:19] = q4[20:0];
            r.data[40] = conv;
            r.data[41] = all;
            pending_results = {pending_results, r};
        endfunction

        // One accepted input transaction.
        function void note_item(logic [1:0] op, logic [31:0] w, logic [2:0] ch);
            int unsigned cnt;
            logic [7:0] m;
            case (op)
                OP_PRESET: if (ch < N_CH) dac[ch] = w[15:0];
                OP_CLEAR: for (int i = 0; i < N_CH; i++) done[i] = 0;
                OP_EVENT: begin
                    case (phase)
                        PH_IDLE, PH_FILLED: begin
                            if (w[31:20] == HDR_MARK) begin
                                psize = (w[27:0] >= 4) ? w[27:0] - 4 : 0;
                                phase = PH_MASK;
                            end else if (w == FILLER && phase == PH_IDLE) begin
                                phase = PH_FILLED;
                            end else begin
                                phase = PH_IDLE;
                                push_error();
                            end
                        end
                        PH_MASK: begin
                            m = w[7:0];
                            cnt = 0;
                            for (int c = 0; c < N_CH; c++) cnt += m[c];
                            if (w[31:28] != 0 || cnt == 0 || psize / cnt == 0) begin
                                phase = PH_IDLE;
                                push_error();
                            end else begin
                                ev_mask = m;
                                wpc = psize / cnt;
                                left = psize;
                                phase = PH_SKIP1;
                            end
                        end
                        PH_SKIP1: phase = PH_SKIP2;
                        PH_SKIP2: begin
                            pend = ev_mask;
                            open_next();
                            phase = PH_DATA;
                        end
                        default: begin
                            if (ch_open) begin
                                if (ch_active) sum += longint'(w[15:0]) + longint'(w[31:16]);
                                wcnt++;
                                if (wcnt >= wpc) begin
                                    if (ch_active) push_update();
                                    open_next();
                                end
                            end
                            if (left > 0) left--;
                            if (left == 0) begin
                                phase = PH_IDLE;
                                ch_open = 0;
                                ch_active = 0;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        endfunction

        // One accepted result transaction, compared with the oldest expectation.
        function void check_result(logic kind, logic [OUT_W-1:0] d);
            t_res e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d data=%h", kind, d));
                return;
            end
            e = pending_results.pop_front();
            if (kind == KIND_ERROR) n_errors++;
            else n_updates++;
            if (kind !== e.kind)
                report($sformatf("kind %0d, want %0d", kind, e.kind));
            if (d[2:0] !== e.data[2:0])
                report($sformatf("channel %0d, want %0d", d[2:0], e.data[2:0]));
            if (d[18:3] !== e.data[18:3])
                report($sformatf("ch%0d dac_level %0d, want %0d", e.data[2:0],
                                 d[18:3], e.data[18:3]));
            if (d[39:19] !== e.data[39:19])
                report($sformatf("ch%0d mean_diff_q4 %0d, want %0d", e.data[2:0],
                                 $signed(d[39:19]), $signed(e.data[39:19])));
            if (d[40] !== e.data[40])
                report($sformatf("ch%0d converged %0d, want %0d", e.data[2:0],
                                 d[40], e.data[40]));
            if (d[41] !== e.data[41])
                report($sformatf("ch%0d all_converged %0d, want %0d", e.data[2:0],
                                 d[41], e.data[41]));
            if (d[47:42] !== 6'd0)
                report($sformatf("padding bits %h not zero", d[47:42]));
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic             o_m_tuser;
    logic             i_cfg_we = 1'b0;
    logic [CH_W-1:0]  i_cfg_addr = '0;
    logic [TGT_W-1:0] i_cfg_data = '0;

    offset_scoreboard sb = new();
    int  n_items = 0;
    int  n_events = 0;
    int  cycles = 0;
    bit  steady = 0;      // no idling on either side while set
    int  stall_left = 0;

    baseline_offset_calibrator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("baseline_offset_calibrator regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, mostly short, a few long.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready = 1'b0;
        end else if (steady) begin
            i_m_tready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = 1'b1;
            if ($urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 3);
                i_m_tready = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transaction, noted with the predictor once accepted.
    task automatic push_item(input logic [1:0] op, input logic [31:0] w,
                             input logic [2:0] ch);
        int g;
        g = pick_gap();
        repeat (g) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata = '0;
        i_s_tdata[1:0] = op;
        i_s_tdata[33:2] = w;
        i_s_tdata[36:34] = ch;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(op, w, ch);
        n_items++;
    endtask

    task automatic push_word(input logic [31:0] w);
        push_item(OP_EVENT, w, 3'($urandom));
    endtask

    // Waits until every result is in and the divider has surely finished.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_targets(input logic [15:0] t [N_CH]);
        wait_idle();
        for (int i = 0; i < N_CH; i++) begin
            @(negedge i_clk);
            i_cfg_we = 1'b1;
            i_cfg_addr = CH_W'(i);
            i_cfg_data = t[i];
            sb.target[i] = t[i];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Sample mode 0: near target, 1: anywhere, 2: rails only.
    function automatic logic [15:0] pick_sample(int c, int mode);
        int v;
        case (mode)
            0: begin
                v = int'(sb.target[c]) + $urandom_range(0, 4) - 2;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
            1: return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Well-formed event; optional filler, and optional control ops mixed in.
    task automatic send_event(input logic [7:0] m, input int per_ch, input int extra,
                              input int mode, input bit filler, input bit mix);
        int k, size;
        k = $countones(m);
        size = k * per_ch + extra + 4;
        if (filler) push_word(FILLER);
        push_word({HDR_MARK, 20'(size)});
        push_word({4'h0, 20'($urandom), m});
        push_word($urandom);
        push_word($urandom);
        for (int c = 0; c < N_CH; c++) begin
            if (m[c]) begin
                for (int j = 0; j < per_ch; j++) begin
                    if (mix && $urandom_range(0, 19) == 0)
                        push_item($urandom_range(0, 1) ? OP_PRESET : OP_CLEAR,
                                  $urandom, 3'($urandom));
                    push_word({pick_sample(c, mode), pick_sample(c, mode)});
                end
            end
        end
        repeat (extra) push_word($urandom);
        n_events++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: push_word($urandom);                                 // bad header word
            1: begin push_word(FILLER); push_word(FILLER); end      // second filler
            2: begin                                                // bad mask word
                push_word({HDR_MARK, 20'($urandom)});
                push_word({4'($urandom_range(1, 15)), 28'($urandom)});
            end
            3: begin                                                // tiny or empty
                push_word({HDR_MARK, 20'($urandom_range(0, 6))});
                push_word({24'h0, 8'($urandom)});
            end
            4: push_item(2'd3, $urandom, 3'($urandom));             // unused op
            default: push_item(OP_PRESET, $urandom, 3'($urandom));
        endcase
    endtask

    function automatic int pick_per_ch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 6);
        if (r < 97) return $urandom_range(7, 30);
        return $urandom_range(60, 200);
    endfunction

    initial begin
        logic [15:0] tg [N_CH];
        logic [7:0] m;
        int r;
        int pc, room;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: rails on targets and levels, every op, each header fault.
        for (int i = 0; i < N_CH; i++) tg[i] = 16'($urandom);
        tg[0] = 16'h0000;
        tg[7] = 16'hFFFF;
        write_targets(tg);
        push_item(2'd3, 32'hFFFF_FFFF, 3'd7);
        push_item(OP_PRESET, 32'hFFFF_FFFF, 3'd0);
        push_item(OP_PRESET, 32'h0000_0000, 3'd7);
        push_item(OP_CLEAR, 32'h0, 3'd0);
        push_word(32'h1234_5678);
        push_word(FILLER);
        push_word(FILLER);
        push_word({HDR_MARK, 20'd2});
        push_word(32'h0000_0001);
        push_word({HDR_MARK, 20'd9});
        push_word(32'h1000_0003);
        push_word({HDR_MARK, 20'd9});
        push_word(32'h0000_FF00);
        push_word({HDR_MARK, 20'd6});
        push_word(32'h0000_0007);
        send_event(8'h81, 1, 1, 2, 1, 0);   // rails, uneven split, after filler
        send_event(8'hFF, 2, 7, 0, 0, 1);   // all channels, ops mixed in
        send_event(8'h81, 1, 0, 2, 0, 0);

        // Random phases, each under a new set of targets.
        for (int p = 0; p < 6; p++) begin
            for (int i = 0; i < N_CH; i++)
                tg[i] = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
            write_targets(tg);
            steady = (p % 3 == 2);
            while (n_items < ITEMS * (p + 1) / 6) begin
                r = $urandom_range(0, 99);
                if (r < 15) push_item(OP_CLEAR, $urandom, 3'($urandom));
                if (r < 88) begin
                    m = 8'($urandom);
                    if (m == 0) m = 8'h01 << $urandom_range(0, 7);
                    // keep the last event of a phase from running far past its share
                    pc = pick_per_ch();
                    room = ITEMS * (p + 1) / 6 - n_items + 40;
                    if (pc * $countones(m) > room) pc = room / $countones(m);
                    if (pc < 1) pc = 1;
                    r = $urandom_range(0, 99);
                    send_event(m, pc, $urandom_range(0, $countones(m) - 1),
                               (r < 50) ? 0 : (r < 85) ? 1 : 2,
                               $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
                end else begin
                    send_noise();
                end
            end
        end
        steady = 0;
        wait_idle();

        $display("%0d transactions in, %0d events, %0d channel updates, %0d header errors",
                 n_items, n_events, sb.n_updates, sb.n_errors);
        $display("target rails and random targets, presets, clears, faults and stalls covered");
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("baseline_offset_calibrator regression: pass");
        end else begin
            $display("baseline_offset_calibrator regression: fail");
        end
        $finish;
    end
endmodule
